// ===== rtl/core/rtp_receiver_statistics_macros.svh =====
// ----------------------------------------------------------------------------
// RTP receiver statistics assertion macros
// Shared property shorthands for the block's checker.
// ----------------------------------------------------------------------------
`ifndef RTP_RECEIVER_STATISTICS_MACROS_SVH
`define RTP_RECEIVER_STATISTICS_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// RTP receiver statistics package
// Payload types, divider interface types and constants of the block.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int unsigned   DVD_W        = 96;
  localparam int unsigned   NARROW_BITS  = 4;
  localparam int unsigned   NARROW_STEPS = DVD_W / NARROW_BITS;
  localparam int unsigned   WIDE_STEPS   = 31;
  localparam int unsigned   CNT_W        = 5;
  localparam logic [9:0]    MS_PER_SEC   = 10'd1000;
  localparam logic [22:0]   LOST_MAX     = 23'h7FFFFF;
  localparam logic [31:0]   RATE_RESET   = 32'd90000;
  localparam int unsigned   JITTER_SHIFT = 4;
  localparam logic [7:0]    FRACTION_MAX = 8'd255;

  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] seq_number;
    logic [31:0] media_timestamp;
    logic [31:0] source_id;
    logic [63:0] arrival_ms;
    logic [31:0] report_ssrc;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  loss_fraction;
    logic [22:0] total_lost;
    logic [31:0] ext_highest_seq;
    logic [31:0] jitter_estimate;
    logic [31:0] report_source;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic             wide;
    logic [DVD_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/rrs_divider.sv =====
// ----------------------------------------------------------------------------
// RTP receiver statistics divider
// Shared restoring divider: four bits a cycle by the fixed milliseconds
// divisor, or one bit a cycle by a 32-bit divisor.
// ----------------------------------------------------------------------------
module rrs_divider (
  input  logic              clk,
  input  logic              rst,
  input  rrs_pkg::div_req_t req,
  output rrs_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic                          wide;
  logic [rrs_pkg::CNT_W-1:0]     cnt;
  logic [rrs_pkg::DVD_W-1:0]     dvd;
  logic [31:0]                   rem;
  logic [31:0]                   dsr;
  logic [31:0]                   quo;

  logic [9:0]                    n_rem_next;
  logic [rrs_pkg::NARROW_BITS-1:0] n_q;
  logic [32:0]                   w_r;
  logic [31:0]                   w_rem_next;
  logic                          w_q;

  always_comb begin
    logic [10:0] r;
    logic [9:0]  nr;
    nr  = rem[9:0];
    n_q = '0;
    for (int i = 0; i < int'(rrs_pkg::NARROW_BITS); i++) begin
      r = {nr, dvd[rrs_pkg::DVD_W-1-i]};
      if (r >= {1'b0, rrs_pkg::MS_PER_SEC}) begin
        nr = 10'(r - {1'b0, rrs_pkg::MS_PER_SEC});
        n_q[rrs_pkg::NARROW_BITS-1-i] = 1'b1;
      end else begin
        nr = r[9:0];
      end
    end
    n_rem_next = nr;
  end

  always_comb begin
    w_r = {rem, dvd[rrs_pkg::DVD_W-1]};
    if (w_r >= {1'b0, dsr}) begin
      w_rem_next = 32'(w_r - {1'b0, dsr});
      w_q        = 1'b1;
    end else begin
      w_rem_next = w_r[31:0];
      w_q        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        wide <= req.wide;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        quo  <= '0;
        cnt  <= req.wide ? rrs_pkg::CNT_W'(rrs_pkg::WIDE_STEPS - 1)
                         : rrs_pkg::CNT_W'(rrs_pkg::NARROW_STEPS - 1);
      end else if (busy) begin
        if (wide) begin
          dvd <= {dvd[rrs_pkg::DVD_W-2:0], 1'b0};
          rem <= w_rem_next;
          quo <= {quo[30:0], w_q};
        end else begin
          dvd <= {dvd[rrs_pkg::DVD_W-1-rrs_pkg::NARROW_BITS:0],
                  {rrs_pkg::NARROW_BITS{1'b0}}};
          rem <= {22'b0, n_rem_next};
          quo <= {quo[31-rrs_pkg::NARROW_BITS:0], n_q};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt  <= cnt - 1'b1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/core/rtp_receiver_statistics.sv =====
// One request at a time: in_ready stays low until the result is registered.
// A first or foreign-source packet goes from S_PKT to S_FIN, where out_valid is raised
// once the output is free. A matching packet runs the shared 32x32 multiply on both
// halves of the arrival time, the divide by 1000 and the jitter update; a report
// computes expected and lost, then a fraction divide that is skipped with no loss.
// Reset clears all statistics and loads 90000.
// ----------------------------------------------------------------------------
// RTP receiver statistics
// Sequencer and state for per-source sequence, loss and jitter tracking.
// ----------------------------------------------------------------------------
module rtp_receiver_statistics (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrs_pkg::out_item_t out_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PKT    = 4'd1;
  localparam logic [3:0] S_MUL0   = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DIVT   = 4'd6;
  localparam logic [3:0] S_JIT0   = 4'd7;
  localparam logic [3:0] S_JIT1   = 4'd8;
  localparam logic [3:0] S_RPT0   = 4'd9;
  localparam logic [3:0] S_RPT1   = 4'd10;
  localparam logic [3:0] S_RPT2   = 4'd11;
  localparam logic [3:0] S_DIVF   = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  logic [3:0]         state;
  logic [31:0]        rate;
  rrs_pkg::in_item_t  item;

  logic               seen_first;
  logic [31:0]        remote_source;
  logic [15:0]        base_sequence;
  logic [15:0]        highest_sequence;
  logic [15:0]        wrap_cycles;
  logic [63:0]        received_count;
  logic [31:0]        jitter_value;
  logic [31:0]        previous_transit;

  logic [63:0]        prod;
  logic [95:0]        acc;
  logic [31:0]        transit;
  logic               jit_en;
  logic signed [33:0] jit_delta;
  logic [31:0]        expected;
  logic [22:0]        lost;
  logic               frac_en;
  logic               res_status;
  logic [7:0]         res_fraction;

  rrs_pkg::div_req_t  div_req;
  rrs_pkg::div_rsp_t  div_rsp;
  rrs_pkg::out_item_t res_item;

  logic [15:0]        ahead;
  logic [31:0]        ext_seq;
  logic [31:0]        diff;
  logic [31:0]        mag;
  logic [31:0]        mul_op;
  logic [63:0]        lost_wide;
  logic [22:0]        lost_clamp;
  logic [33:0]        delta_mag;
  logic [33:0]        jit_step;

  rrs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE);
  assign ahead    = item.seq_number - highest_sequence;
  assign ext_seq  = {wrap_cycles, highest_sequence};
  assign diff     = transit - previous_transit;
  assign mag      = diff[31] ? (32'd0 - diff) : diff;
  assign mul_op   = (state == S_MUL1) ? item.arrival_ms[63:32] : item.arrival_ms[31:0];

  always_comb begin
    lost_wide = ({32'b0, expected} > received_count) ? ({32'b0, expected} - received_count)
                                                      : 64'd0;
    lost_clamp = (lost_wide > {41'b0, rrs_pkg::LOST_MAX}) ? rrs_pkg::LOST_MAX
                                                          : lost_wide[22:0];
  end

  always_comb begin
    delta_mag = 34'(-jit_delta);
    if (jit_delta < 0) begin
      jit_step = 34'(-(delta_mag >> rrs_pkg::JITTER_SHIFT));
    end else begin
      jit_step = 34'(jit_delta >>> rrs_pkg::JITTER_SHIFT);
    end
  end

  always_comb begin
    div_req.start    = (state == S_DSTART) || ((state == S_RPT2) && frac_en);
    div_req.wide     = (state == S_RPT2);
    div_req.dividend = div_req.wide ? {lost, 8'b0, 65'b0} : acc;
    div_req.divisor  = div_req.wide ? expected : {22'b0, rrs_pkg::MS_PER_SEC};
  end

  always_comb begin
    res_item        = '0;
    res_item.status = res_status;
    if (item.mode == rrs_pkg::MODE_REPORT) begin
      res_item.loss_fraction   = res_fraction;
      res_item.total_lost      = lost;
      res_item.ext_highest_seq = ext_seq;
      res_item.jitter_estimate = jitter_value;
      res_item.report_source   = (item.report_ssrc != 32'd0) ? item.report_ssrc
                                                             : remote_source;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      rate             <= rrs_pkg::RATE_RESET;
      out_valid        <= 1'b0;
      seen_first       <= 1'b0;
      remote_source    <= '0;
      base_sequence    <= '0;
      highest_sequence <= '0;
      wrap_cycles      <= '0;
      received_count   <= '0;
      jitter_value     <= '0;
      previous_transit <= '0;
    end else begin
      if (cfg_wr_en) begin
        rate <= cfg_wr_data;
      end
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= (in_data.mode == rrs_pkg::MODE_REPORT) ? S_RPT0 : S_PKT;
          end
        end
        S_PKT: begin
          if (!seen_first) begin
            res_status       <= rrs_pkg::STATUS_OK;
            seen_first       <= 1'b1;
            remote_source    <= item.source_id;
            base_sequence    <= item.seq_number;
            highest_sequence <= item.seq_number;
            wrap_cycles      <= '0;
            received_count   <= 64'd1;
            jitter_value     <= '0;
            previous_transit <= '0;
            state            <= S_FIN;
          end else if (item.source_id != remote_source) begin
            res_status <= rrs_pkg::STATUS_MISMATCH;
            state      <= S_FIN;
          end else begin
            res_status <= rrs_pkg::STATUS_OK;
            if ((ahead != 16'd0) && !ahead[15]) begin
              if (item.seq_number < highest_sequence) begin
                wrap_cycles <= wrap_cycles + 16'd1;
              end
              highest_sequence <= item.seq_number;
            end
            received_count <= received_count + 64'd1;
            state          <= S_MUL0;
          end
        end
        S_MUL0: begin
          prod  <= mul_op * rate;
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc   <= {32'b0, prod};
          prod  <= mul_op * rate;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc[95:32] <= acc[95:32] + prod;
          state      <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIVT;
        end
        S_DIVT: begin
          if (div_rsp.done) begin
            transit <= div_rsp.quotient - item.media_timestamp;
            state   <= S_JIT0;
          end
        end
        S_JIT0: begin
          jit_en    <= (previous_transit != 32'd0);
          jit_delta <= signed'({2'b0, mag} - {2'b0, jitter_value});
          state     <= S_JIT1;
        end
        S_JIT1: begin
          if (jit_en) begin
            jitter_value <= jitter_value + jit_step[31:0];
          end
          previous_transit <= transit;
          state            <= S_FIN;
        end
        S_RPT0: begin
          res_status <= rrs_pkg::STATUS_OK;
          expected   <= ext_seq - {16'b0, base_sequence} + 32'd1;
          state      <= S_RPT1;
        end
        S_RPT1: begin
          lost    <= lost_clamp;
          frac_en <= (expected != 32'd0) && (lost_clamp != 23'd0);
          state   <= S_RPT2;
        end
        S_RPT2: begin
          if (frac_en) begin
            state <= S_DIVF;
          end else begin
            res_fraction <= '0;
            state        <= S_FIN;
          end
        end
        S_DIVF: begin
          if (div_rsp.done) begin
            res_fraction <= (div_rsp.quotient > {24'b0, rrs_pkg::FRACTION_MAX})
                            ? rrs_pkg::FRACTION_MAX : div_rsp.quotient[7:0];
            state        <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data  <= res_item;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rrs_checker.sv =====
// ----------------------------------------------------------------------------
// RTP receiver statistics checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "rtp_receiver_statistics_macros.svh"

module rrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rrs_pkg::out_item_t out_data
);

  logic out_stalled;
  logic in_taken;
  logic foreign;
  logic fields_zero;
  logic frac_shown;
  logic loss_shown;

  assign out_stalled = out_valid && !out_ready;
  assign in_taken    = in_valid && in_ready;
  assign foreign     = out_valid && (out_data.status == rrs_pkg::STATUS_MISMATCH);
  assign fields_zero = (out_data.loss_fraction == 8'd0) && (out_data.ext_highest_seq == 32'd0)
                       && (out_data.report_source == 32'd0);
  assign frac_shown  = out_valid && (out_data.loss_fraction != 8'd0);
  assign loss_shown  = (out_data.total_lost != 23'd0);

  `RRS_ASSERT_NEXT(a_out_hold, out_stalled, out_valid && $stable(out_data), "result not held")
  `RRS_ASSERT_NEXT(a_one_request, in_taken, !in_ready, "request taken while busy")
  `RRS_ASSERT_NOW(a_mismatch_clean, foreign, fields_zero, "foreign result has report fields")
  `RRS_ASSERT_NOW(a_fraction_needs_loss, frac_shown, loss_shown, "fraction without loss")

endmodule

bind rtp_receiver_statistics rrs_checker u_rrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/rtp_receiver_statistics_test.sv =====
// ----------------------------------------------------------------------------
// RTP receiver statistics testbench
// Sends packet and report requests through the valid/ready ports and keeps
// its own copy of the sequence, loss and jitter statistics to predict every
// result. Covers the corner cases first, then media clock rate changes, a long
// receiver hold-off, several idle and stall mixes, and a loss-clamp stream.
// ----------------------------------------------------------------------------
module rtp_receiver_statistics_test;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned HOLDOFF_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [31:0]        cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  rrs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rrs_pkg::out_item_t out_data;

  rtp_receiver_statistics dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always #5 clk = ~clk;

  // Predicted copy of the block's register and statistics.
  logic [31:0] rate_model = rrs_pkg::RATE_RESET;
  logic        seen_first = 1'b0;
  logic [31:0] latched_src = '0;
  logic [15:0] first_seq = '0;
  logic [15:0] top_seq = '0;
  logic [15:0] wraps = '0;
  logic [63:0] rx_count = '0;
  logic [31:0] jitter_q = '0;
  logic [31:0] prior_transit = '0;

  rrs_pkg::out_item_t stats_due[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_asked = 0;
  int unsigned holdoff_taken = 0;
  int unsigned holdoff_left = 0;
  int unsigned idle_before = 0;
  bit          valid_held = 1'b0;
  logic [31:0] stream_ts = '0;
  logic [63:0] stream_ms = '0;

  function automatic rrs_pkg::out_item_t update_statistics(input rrs_pkg::in_item_t req);
    rrs_pkg::out_item_t res;
    logic [15:0] ahead;
    logic [95:0] product;
    logic [31:0] arrival;
    logic [31:0] transit;
    logic [31:0] diff;
    longint      mag;
    longint      delta;
    logic [31:0] ext;
    logic [31:0] expd;
    logic [63:0] lost;
    logic [63:0] frac;
    res = '0;
    if (req.mode == rrs_pkg::MODE_REPORT) begin
      ext = {wraps, top_seq};
      expd = ext - {16'd0, first_seq} + 32'd1;
      lost = ({32'd0, expd} > rx_count) ? {32'd0, expd} - rx_count : 64'd0;
      if (lost > {41'd0, rrs_pkg::LOST_MAX}) lost = {41'd0, rrs_pkg::LOST_MAX};
      frac = '0;
      if (expd != 0 && lost != 0) begin
        frac = (lost * 64'd256) / {32'd0, expd};
        if (frac > {56'd0, rrs_pkg::FRACTION_MAX}) frac = {56'd0, rrs_pkg::FRACTION_MAX};
      end
      res.status = rrs_pkg::STATUS_OK;
      res.loss_fraction = frac[7:0];
      res.total_lost = lost[22:0];
      res.ext_highest_seq = ext;
      res.jitter_estimate = jitter_q;
      res.report_source = (req.report_ssrc != 0) ? req.report_ssrc : latched_src;
      return res;
    end
    if (!seen_first) begin
      seen_first = 1'b1;
      latched_src = req.source_id;
      first_seq = req.seq_number;
      top_seq = req.seq_number;
      wraps = '0;
      rx_count = '0;
      jitter_q = '0;
      prior_transit = '0;
    end else if (req.source_id != latched_src) begin
      res.status = rrs_pkg::STATUS_MISMATCH;
      return res;
    end else begin
      ahead = req.seq_number - top_seq;
      if (ahead != 0 && ahead < 16'h8000) begin
        if (req.seq_number < top_seq) wraps = wraps + 16'd1;
        top_seq = req.seq_number;
      end
      product = {32'd0, req.arrival_ms} * {64'd0, rate_model};
      arrival = 32'(product / 96'd1000);
      transit = arrival - req.media_timestamp;
      if (prior_transit != 0) begin
        diff = transit - prior_transit;
        mag = diff[31] ? longint'(64'h1_0000_0000 - {32'd0, diff})
                       : longint'({32'd0, diff});
        delta = (mag - longint'({32'd0, jitter_q})) / 16;
        jitter_q = 32'(longint'({32'd0, jitter_q}) + delta);
      end
      prior_transit = transit;
    end
    rx_count = rx_count + 64'd1;
    res.status = rrs_pkg::STATUS_OK;
    return res;
  endfunction

  function automatic rrs_pkg::in_item_t packet_item(input logic [15:0] seq,
                                                    input logic [31:0] ts,
                                                    input logic [31:0] src,
                                                    input logic [63:0] ms);
    rrs_pkg::in_item_t req;
    req.mode = rrs_pkg::MODE_PACKET;
    req.seq_number = seq;
    req.media_timestamp = ts;
    req.source_id = src;
    req.arrival_ms = ms;
    req.report_ssrc = $urandom;
    return req;
  endfunction

  function automatic rrs_pkg::in_item_t report_item(input logic [31:0] ssrc);
    rrs_pkg::in_item_t req;
    req.mode = rrs_pkg::MODE_REPORT;
    req.seq_number = 16'($urandom);
    req.media_timestamp = $urandom;
    req.source_id = $urandom;
    req.arrival_ms = {$urandom, $urandom};
    req.report_ssrc = ssrc;
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < 100) begin
      $display("mismatch at cycle %0d: %s got %0h, expected %0h", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  task automatic send_request(input rrs_pkg::in_item_t req);
    int unsigned gap;
    repeat (idle_before) @(posedge clk);
    idle_before = 0;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    stats_due.push_back(update_statistics(req));
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
      idle_before = gap;
    end else begin
      valid_held = 1'b1;
    end
  endtask

  task automatic drop_valid();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  task automatic wait_for_results();
    drop_valid();
    while (stats_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_clock_rate(input logic [31:0] rate);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rate_model = rate;
  endtask

  task automatic send_stream_packet(input int step);
    int unsigned gap_ms;
    gap_ms = $urandom_range(46, 20);
    stream_ms += 64'(gap_ms);
    stream_ts += 32'(({32'd0, rate_model} * gap_ms) / 1000) + $urandom_range(400, 0) - 200;
    send_request(packet_item(top_seq + 16'(step), stream_ts, latched_src, stream_ms));
  endtask

  task automatic send_random_item();
    int unsigned pick;
    int unsigned kind;
    int          step;
    pick = $urandom_range(99);
    if (pick < 65) begin
      kind = $urandom_range(99);
      if (kind < 75) step = 1;
      else if (kind < 85) step = $urandom_range(30, 2);
      else if (kind < 90) step = 0;
      else if (kind < 97) step = -int'($urandom_range(5, 1));
      else step = $urandom_range(65535);
      send_stream_packet(step);
    end else if (pick < 72) begin
      send_request(packet_item(16'($urandom), $urandom, latched_src, {$urandom, $urandom}));
    end else if (pick < 80) begin
      send_request(packet_item(16'($urandom), $urandom, latched_src ^ ($urandom | 32'd1),
                               {$urandom, $urandom}));
    end else begin
      send_request(report_item($urandom_range(1) ? 32'd0 : $urandom));
    end
  endtask

  task automatic test_corner_cases();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(report_item(32'd0));
    send_request(report_item(32'hFFFF_FFFF));
    send_request(packet_item(16'hFFF0, 32'd0, 32'hA5A5_5A5A, 64'd0));
    send_request(packet_item(16'hFFF1, 32'd0, 32'd0, 64'd5));
    send_request(packet_item(16'hFFF1, 32'd0, 32'hFFFF_FFFF, 64'd5));
    send_request(packet_item(16'hFFF1, 32'd0, latched_src, 64'd0));
    send_request(packet_item(16'hFFFF, 32'hFFFF_FFFF, latched_src, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(packet_item(16'h0002, 32'd1000, latched_src, 64'd40));
    send_request(packet_item(16'h0002, 32'd4000, latched_src, 64'd80));
    send_request(packet_item(16'hFFFE, 32'd7000, latched_src, 64'd120));
    send_request(report_item(32'd0));
    send_request(packet_item(16'h8002, 32'd9000, latched_src, 64'd160));
    send_request(packet_item(16'h8001, 32'd12000, latched_src, 64'd200));
    send_request(report_item(32'h1234_5678));
    send_request(packet_item(16'h8005, 32'h8000_0000, latched_src, 64'd1_000_000));
    send_request(packet_item(16'h8006, 32'd0, latched_src, 64'h8000_0000_0000_0000));
    send_request(report_item(32'd0));
    stream_ts = 32'd50_000;
    stream_ms = 64'd1_000;
    wait_for_results();
  endtask

  task automatic test_clock_rates();
    logic [31:0] rates[5];
    rates[0] = 32'd1;
    rates[1] = 32'hFFFF_FFFF;
    rates[2] = 32'd8000;
    rates[3] = 32'd48000;
    rates[4] = $urandom_range(32'hFFFF_FFFF, 1);
    sender_idle_pct = 13;
    recv_stall_pct = 13;
    foreach (rates[i]) begin
      write_clock_rate(rates[i]);
      repeat (40) send_random_item();
      wait_for_results();
    end
    write_clock_rate(rrs_pkg::RATE_RESET);
  endtask

  task automatic test_output_holdoff();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_asked++;
    repeat (8) send_stream_packet(1);
    send_request(report_item(32'd0));
    wait_for_results();
    repeat (10) send_random_item();
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];
    idle_mix = '{0, 66, 0, 13};
    stall_mix = '{0, 0, 66, 13};
    foreach (idle_mix[i]) begin
      sender_idle_pct = idle_mix[i];
      recv_stall_pct = stall_mix[i];
      repeat (300) send_random_item();
    end
    wait_for_results();
  endtask

  task automatic test_loss_clamp();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 300; n++) begin
      send_stream_packet(16'h7FFF);
      if (n % 50 == 49) send_request(report_item(32'd0));
    end
    wait_for_results();
  endtask

  always @(posedge clk) begin
    if (holdoff_taken != holdoff_asked) begin
      holdoff_taken <= holdoff_asked;
      holdoff_left <= HOLDOFF_CYCLES;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  always @(posedge clk) begin
    out_ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    rrs_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (stats_due.size() == 0) begin
        report_mismatch("result with no request waiting", 64'(out_data.ext_highest_seq), 64'd0);
      end else begin
        want = stats_due.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.loss_fraction !== want.loss_fraction)
          report_mismatch("loss_fraction", 64'(out_data.loss_fraction),
                          64'(want.loss_fraction));
        if (out_data.total_lost !== want.total_lost)
          report_mismatch("total_lost", 64'(out_data.total_lost), 64'(want.total_lost));
        if (out_data.ext_highest_seq !== want.ext_highest_seq)
          report_mismatch("ext_highest_seq", 64'(out_data.ext_highest_seq),
                          64'(want.ext_highest_seq));
        if (out_data.jitter_estimate !== want.jitter_estimate)
          report_mismatch("jitter_estimate", 64'(out_data.jitter_estimate),
                          64'(want.jitter_estimate));
        if (out_data.report_source !== want.report_source)
          report_mismatch("report_source", 64'(out_data.report_source),
                          64'(want.report_source));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_clock_rates();
    test_output_holdoff();
    test_random_traffic();
    test_loss_clamp();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
